// ----- sv/fcm_pkg.sv -----
// shared constants, codes and controller/datapath structs for the fully connected layer
`timescale 1ns / 1ps
package fcm_pkg;

  localparam int MAX_IN     = 1024;
  localparam int MAX_OUT    = 64;
  localparam int IN_AW      = $clog2(MAX_IN);
  localparam int OUT_AW     = $clog2(MAX_OUT);
  localparam int W_DEPTH    = MAX_IN * MAX_OUT;

  localparam int CNT_IN_W   = 11;
  localparam int CNT_OUT_W  = 7;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int ACTION_W   = 2;

  localparam int VAL_W      = 16;
  localparam int BIAS_W     = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = 48;
  localparam int RES_W      = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_BIAS   = 2'd1,
    ACT_FEED   = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic              wr_weight;
    logic              wr_bias;
    logic              load;
    logic              first;
    logic              issue;
    logic [OUT_AW-1:0] k;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic act_ok;
    logic act_last;
    logic vec_last;
    logic adv;
    logic busy;
  } sts_t;

endpackage

// ----- sv/fcm_in_if.sv -----
// input word channel: action, indexes, weight/activation and bias
`timescale 1ns / 1ps
interface fcm_in_if;
  import fcm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic [OUT_AW-1:0]        out_index;
  logic [IN_AW-1:0]         in_index;
  logic signed [VAL_W-1:0]  value;
  logic signed [BIAS_W-1:0] bias_value;

  modport source (output valid, action, out_index, in_index, value, bias_value, input ready);
  modport sink   (input valid, action, out_index, in_index, value, bias_value, output ready);
endinterface

// ----- sv/fcm_out_if.sv -----
// result word channel: neuron index, saturated result and end of vector flag
`timescale 1ns / 1ps
interface fcm_out_if;
  import fcm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUT_AW-1:0]       neuron_index;
  logic signed [RES_W-1:0] result;
  logic                    last;

  modport source (output valid, neuron_index, result, last, input ready);
  modport sink   (input valid, neuron_index, result, last, output ready);
endinterface

// ----- sv/fcm_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module fcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- sv/fcm_ctrl.sv -----
// controller: word decode and per-neuron sweep sequencing
`timescale 1ns / 1ps
module fcm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [fcm_pkg::ACTION_W-1:0]  in_action,
  output logic                          in_ready,
  output fcm_pkg::cmd_t                 cmd,
  input  fcm_pkg::sts_t                 sts
);
  import fcm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN} state_t;

  state_t            state_r, state_nxt;
  logic [OUT_AW-1:0] k_r, k_nxt;
  logic              started_r, started_nxt;
  logic              accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.wr_weight = accept && (in_action == ACT_WEIGHT);
    cmd.wr_bias   = accept && (in_action == ACT_BIAS);
    cmd.load      = accept && (in_action == ACT_FEED) && sts.act_ok;
    cmd.first     = !started_r;
    cmd.issue     = (state_r == S_SWEEP);
    cmd.k         = k_r;
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    started_nxt = started_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          started_nxt = 1'b1;
          k_nxt       = '0;
          state_nxt   = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sts.adv) begin
          if (k_r == OUT_AW'(MAX_OUT - 1)) begin
            state_nxt = S_DRAIN;
            if (sts.vec_last) begin
              started_nxt = 1'b0;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      started_r <= started_nxt;
    end
  end
endmodule

// ----- sv/fcm_dp.sv -----
// datapath: config registers, weight/bias/accumulator rams, mac pipeline, output register
`timescale 1ns / 1ps
module fcm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [fcm_pkg::OUT_AW-1:0]     in_out_index,
  input  logic [fcm_pkg::IN_AW-1:0]      in_in_index,
  input  logic signed [fcm_pkg::VAL_W-1:0]  in_value,
  input  logic signed [fcm_pkg::BIAS_W-1:0] in_bias_value,
  input  fcm_pkg::cmd_t                  cmd,
  output fcm_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fcm_pkg::OUT_AW-1:0]     out_neuron_index,
  output logic signed [fcm_pkg::RES_W-1:0] out_result,
  output logic                           out_last
);
  import fcm_pkg::*;

  // configuration
  logic [CNT_IN_W-1:0]  in_count_r, nin;
  logic [CNT_OUT_W-1:0] out_count_r, nout;
  logic                 bias_en_r;

  // current activation word
  logic signed [VAL_W-1:0] act_r;
  logic [IN_AW-1:0]        ii_r;
  logic                    first_r;
  logic                    vec_last_r;

  // pipeline
  logic                     s1_v_r, s2_v_r;
  logic [OUT_AW-1:0]        s1_k_r, s2_k_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         base_r;
  logic                     s2_use_r;
  logic                     s1_use, emit, adv, rd_en, out_load;
  logic [ACC_W-1:0]         sum, init_val;
  logic [RES_W-1:0]         sat;

  logic [VAL_W-1:0]  w_rd;
  logic [BIAS_W-1:0] b_rd;
  logic [ACC_W-1:0]  acc_rd;

  // output register
  logic                    out_valid_r;
  logic [OUT_AW-1:0]       neuron_r;
  logic signed [RES_W-1:0] result_r;
  logic                    last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= CNT_IN_W'(MAX_IN);
      out_count_r <= CNT_OUT_W'(MAX_OUT);
      bias_en_r   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IN_COUNT) begin
        in_count_r <= cfg_wdata[CNT_IN_W-1:0];
      end
      if (cfg_index == CFG_OUT_COUNT) begin
        out_count_r <= cfg_wdata[CNT_OUT_W-1:0];
      end
      if (cfg_index == CFG_BIAS_EN) begin
        bias_en_r <= cfg_wdata[0];
      end
    end
  end

  // zero counts act as one, larger ones saturate at the store size
  always_comb begin
    priority if (in_count_r == '0) nin = CNT_IN_W'(1);
    else if (in_count_r > CNT_IN_W'(MAX_IN)) nin = CNT_IN_W'(MAX_IN);
    else nin = in_count_r;
    priority if (out_count_r == '0) nout = CNT_OUT_W'(1);
    else if (out_count_r > CNT_OUT_W'(MAX_OUT)) nout = CNT_OUT_W'(MAX_OUT);
    else nout = out_count_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r      <= in_value;
      ii_r       <= in_in_index;
      first_r    <= cmd.first;
      vec_last_r <= sts.act_last;
    end
  end

  assign emit     = s2_use_r && vec_last_r;
  assign adv      = !(s2_v_r && emit && out_valid_r && !out_ready);
  assign rd_en    = cmd.issue && adv;
  assign out_load = s2_v_r && emit && (!out_valid_r || out_ready);
  assign s1_use   = ({1'b0, s1_k_r} < nout);

  fcm_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk  (clk),
    .we   (cmd.wr_weight),
    .waddr({in_out_index, in_in_index}),
    .wdata(in_value),
    .re   (rd_en),
    .raddr({cmd.k, ii_r}),
    .rdata(w_rd)
  );

  fcm_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUT)) u_bias_ram (
    .clk  (clk),
    .we   (cmd.wr_bias),
    .waddr(in_out_index),
    .wdata(in_bias_value),
    .re   (rd_en),
    .raddr(cmd.k),
    .rdata(b_rd)
  );

  fcm_ram #(.WIDTH(ACC_W), .DEPTH(MAX_OUT)) u_acc_ram (
    .clk  (clk),
    .we   (s2_v_r && adv),
    .waddr(s2_k_r),
    .wdata(sum),
    .re   (rd_en),
    .raddr(cmd.k),
    .rdata(acc_rd)
  );

  assign init_val = bias_en_r ? {{(ACC_W-BIAS_W){b_rd[BIAS_W-1]}}, b_rd} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_k_r   <= cmd.k;
      s2_k_r   <= s1_k_r;
      prod_r   <= act_r * $signed(w_rd);
      base_r   <= first_r ? init_val : acc_rd;
      s2_use_r <= s1_use;
    end
  end

  // neurons beyond out_count keep their start value
  assign sum = base_r + (s2_use_r ? {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} : '0);

  always_comb begin
    if (&sum[ACC_W-1:RES_W-1] || ~|sum[ACC_W-1:RES_W-1]) begin
      sat = sum[RES_W-1:0];
    end else if (sum[ACC_W-1]) begin
      sat = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      neuron_r <= s2_k_r;
      result_r <= $signed(sat);
      last_r   <= ({1'b0, s2_k_r} == nout - CNT_OUT_W'(1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_neuron_index = neuron_r;
  assign out_result       = result_r;
  assign out_last         = last_r;

  always_comb begin
    sts.act_ok   = ({1'b0, in_in_index} < nin);
    sts.act_last = ({1'b0, in_in_index} == nin - CNT_IN_W'(1));
    sts.vec_last = vec_last_r;
    sts.adv      = adv;
    sts.busy     = s1_v_r || s2_v_r;
  end
endmodule

// ----- sv/fully_connected_layer_mac.sv -----
// top level of the fully connected layer: controller, datapath and channel hookup
//
//   channel  dir  handshake          contents
//   in_ch    in   valid/ready        action, out_index, in_index, value, bias_value
//   out_ch   out  valid/ready        neuron_index, result, last
//   cfg_*    in   cfg_we only        cfg_index, cfg_wdata (in_count, out_count, bias_enable)
//
// a weight write, bias write or ignored word leaves the input ready
// an activation word holds the input while one shared multiply-accumulate unit walks
// all MAX_OUT accumulators through the ram reads, product/base registers and write-back
// results come out of a one-word output register; a stalled result holds the sweep
// reset is synchronous and active low; the rams are not cleared, accumulators are
// loaded with bias or zero by the first activation of each vector
`timescale 1ns / 1ps
module fully_connected_layer_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  fcm_in_if.sink                        in_ch,
  fcm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [fcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcm_pkg::CFG_W-1:0]     cfg_wdata
);
  import fcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // decodes each word and steps the neuron counter through the sweep
  fcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_action(in_ch.action),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // stores, mac pipeline, saturation and the output word register
  fcm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_out_index    (in_ch.out_index),
    .in_in_index     (in_ch.in_index),
    .in_value        (in_ch.value),
    .in_bias_value   (in_ch.bias_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_neuron_index(out_ch.neuron_index),
    .out_result      (out_ch.result),
    .out_last        (out_ch.last)
  );
endmodule

// ----- sv/fcm_checker.sv -----
// port-level checks on the fully connected layer, bound to the top level
`timescale 1ns / 1ps
module fcm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [fcm_pkg::ACTION_W-1:0]  in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fcm_pkg::OUT_AW-1:0]    out_neuron_index,
  input logic [fcm_pkg::RES_W-1:0]     out_result,
  input logic                          out_last
);
  import fcm_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_neuron_index))
    else $error("result word changed while stalled");

  // results only appear while an activation sweep holds the input
  a_out_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while input ready");

  // store writes and dropped non-activation words never block the input
  a_write_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action != ACT_FEED) |=> in_ready)
    else $error("input blocked after a non-activation word");

  // nothing follows the last result of a vector straight away
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result word right after end of vector");
endmodule

bind fully_connected_layer_mac fcm_checker u_fcm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_action       (in_ch.action),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_neuron_index(out_ch.neuron_index),
  .out_result      (out_ch.result),
  .out_last        (out_ch.last)
);
